@@ rtl/bresenham_3d_ray_voxel_walker_macros.svh @@
// Assertion macros for the ray voxel walker.
// Each macro expects clk and rst_n in scope.
`ifndef BRESENHAM_3D_RAY_VOXEL_WALKER_MACROS_SVH
`define BRESENHAM_3D_RAY_VOXEL_WALKER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BVW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define BVW_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BVW_ASSERT(label, prop, msg)

`define BVW_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ rtl/bvw_pkg.sv @@
package bvw_pkg;

    localparam int COORD_W   = 6;
    localparam int ERR_W     = 10;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 1'b1;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    typedef logic [COORD_W-1:0]      coord_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

    // One classified ray, ready to walk. Axis arrays are indexed x=0, y=1, z=2.
    typedef struct packed {
        coord_t [2:0] cur;
        coord_t [2:0] dst;
        logic   [2:0] up;     // 1: axis steps by +1, 0: by -1
        axis_t        axis;   // dominant axis
        coord_t       da;
        coord_t       db1;
        coord_t       db2;
        err_t         p1;
        err_t         p2;
    } job_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } voxel_t;

    function automatic err_t twice(input coord_t d);
        return err_t'({d, 1'b0});
    endfunction

endpackage

@@ rtl/bvw_fifo.sv @@
`include "bresenham_3d_ray_voxel_walker_macros.svh"

module bvw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `BVW_ASSERT(a_count_bound, count_reg <= CNT_FULL, "fifo count above depth")
    `BVW_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty, "fifo empty after push")
    `BVW_ASSERT_NEXT(a_pop_frees, do_pop && !do_push, !full, "fifo full after pop")

endmodule

@@ rtl/bvw_front.sv @@
module bvw_front
    import bvw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  coord_t               start_x,
    input  coord_t               start_y,
    input  coord_t               start_z,
    input  coord_t               end_x,
    input  coord_t               end_y,
    input  coord_t               end_z,
    input  logic                 job_full,
    output logic                 job_push,
    output job_t                 job
);

    logic [CFG_W-1:0] grid_x_reg, grid_x_next;
    logic [CFG_W-1:0] grid_y_reg, grid_y_next;
    coord_t [2:0]     c, e, d;
    logic   [2:0]     up;
    logic             in_grid;
    axis_t            axis;
    coord_t           da, db1, db2;

    always_comb
    begin
        grid_x_next = grid_x_reg;
        grid_y_next = grid_y_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_X: grid_x_next = cfg_data;
                REG_GRID_Y: grid_y_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg <= GRID_RESET;
            grid_y_reg <= GRID_RESET;
        end
        else
        begin
            grid_x_reg <= grid_x_next;
            grid_y_reg <= grid_y_next;
        end
    end

    assign c = {start_z, start_y, start_x};
    assign e = {end_z, end_y, end_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up[i] = e[i] > c[i];
            d[i]  = up[i] ? e[i] - c[i] : c[i] - e[i];
        end
    end

    // Ties go to x, then y.
    always_comb
    begin
        if (d[0] >= d[1] && d[0] >= d[2])
        begin
            axis = AXIS_X;
            da   = d[0];
            db1  = d[1];
            db2  = d[2];
        end
        else if (d[1] >= d[0] && d[1] >= d[2])
        begin
            axis = AXIS_Y;
            da   = d[1];
            db1  = d[0];
            db2  = d[2];
        end
        else
        begin
            axis = AXIS_Z;
            da   = d[2];
            db1  = d[1];
            db2  = d[0];
        end
    end

    assign in_grid = ({1'b0, end_x} < grid_x_reg) && ({1'b0, end_y} < grid_y_reg);

    assign full     = job_full;
    assign job_push = push && !job_full && in_grid;

    always_comb
    begin
        job.cur  = c;
        job.dst  = e;
        job.up   = up;
        job.axis = axis;
        job.da   = da;
        job.db1  = db1;
        job.db2  = db2;
        job.p1   = twice(db1) - err_t'(da);
        job.p2   = twice(db2) - err_t'(da);
    end

endmodule

@@ rtl/bvw_walker.sv @@
`include "bresenham_3d_ray_voxel_walker_macros.svh"

module bvw_walker
    import bvw_pkg::*;
#(
    parameter int GRID_MAX = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   job_empty,
    input  job_t   job,
    output logic   job_pop,
    input  logic   out_full,
    output logic   out_push,
    output voxel_t out_voxel
);

    localparam int STEP_W = $clog2(GRID_MAX);
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(GRID_MAX - 1);

    walk_state_t      state_reg, state_next;
    coord_t [2:0]     cur_reg, cur_next;
    coord_t [2:0]     dst_reg, dst_next;
    logic   [2:0]     up_reg, up_next;
    axis_t            axis_reg, axis_next;
    coord_t           da_reg, da_next;
    coord_t           db1_reg, db1_next;
    coord_t           db2_reg, db2_next;
    err_t             p1_reg, p1_next;
    err_t             p2_reg, p2_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic             pend_valid_reg, pend_valid_next;
    coord_t [2:0]     pend_reg, pend_next;

    logic             advance;   // walker may act this cycle
    logic             cont;      // loop condition holds
    logic             hit;       // stepped onto the end column
    logic             finish;
    logic   [2:0]     step_en;
    coord_t [2:0]     nxt;
    logic             p1_ge, p2_ge;

    assign p1_ge   = !p1_reg[ERR_W-1];
    assign p2_ge   = !p2_reg[ERR_W-1];
    assign advance = (state_reg == WALK_RUN) && !out_full;
    assign cont    = (cur_reg[axis_reg] != dst_reg[axis_reg]) && (cnt_reg != STEP_LIMIT);

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  step_en = {p2_ge, p1_ge, 1'b1};
            AXIS_Y:  step_en = {p2_ge, 1'b1, p1_ge};
            AXIS_Z:  step_en = {1'b1, p1_ge, p2_ge};
            default: step_en = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!step_en[i])
            begin
                nxt[i] = cur_reg[i];
            end
            else if (up_reg[i])
            begin
                nxt[i] = cur_reg[i] + 1'b1;
            end
            else
            begin
                nxt[i] = cur_reg[i] - 1'b1;
            end
        end
    end

    assign hit    = (nxt[0] == dst_reg[0]) && (nxt[1] == dst_reg[1]);
    assign finish = advance && (!cont || hit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WALK_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = WALK_RUN;
                end
            end
            WALK_RUN:
            begin
                if (finish)
                begin
                    state_next = WALK_IDLE;
                end
            end
            default: state_next = WALK_IDLE;
        endcase
    end

    // datapath and outputs; one voxel is held back so the last one can be marked
    always_comb
    begin
        job_pop         = 1'b0;
        out_push        = 1'b0;
        out_voxel.x     = pend_reg[0];
        out_voxel.y     = pend_reg[1];
        out_voxel.z     = pend_reg[2];
        out_voxel.last  = 1'b0;
        cur_next        = cur_reg;
        dst_next        = dst_reg;
        up_next         = up_reg;
        axis_next       = axis_reg;
        da_next         = da_reg;
        db1_next        = db1_reg;
        db2_next        = db2_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        case (state_reg)
            WALK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop         = 1'b1;
                    cur_next        = job.cur;
                    dst_next        = job.dst;
                    up_next         = job.up;
                    axis_next       = job.axis;
                    da_next         = job.da;
                    db1_next        = job.db1;
                    db2_next        = job.db2;
                    p1_next         = job.p1;
                    p2_next         = job.p2;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            WALK_RUN:
            begin
                if (finish)
                begin
                    out_push        = pend_valid_reg;
                    out_voxel.last  = 1'b1;
                    pend_valid_next = 1'b0;
                end
                else if (advance)
                begin
                    out_push        = pend_valid_reg;
                    cur_next        = nxt;
                    p1_next         = p1_reg - (p1_ge ? twice(da_reg) : '0) + twice(db1_reg);
                    p2_next         = p2_reg - (p2_ge ? twice(da_reg) : '0) + twice(db2_reg);
                    cnt_next        = cnt_reg + 1'b1;
                    pend_next       = nxt;
                    pend_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= WALK_IDLE;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        dst_reg  <= dst_next;
        up_reg   <= up_next;
        axis_reg <= axis_next;
        da_reg   <= da_next;
        db1_reg  <= db1_next;
        db2_reg  <= db2_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        pend_reg <= pend_next;
    end

    `BVW_ASSERT(a_push_has_voxel, !out_push || pend_valid_reg, "push without held voxel")
    `BVW_ASSERT_NEXT(a_last_ends_ray, out_push && out_voxel.last, state_reg == WALK_IDLE,
        "walker still running after last voxel")
    `BVW_ASSERT_NEXT(a_pop_starts_walk, job_pop, state_reg == WALK_RUN && !pend_valid_reg,
        "walk not started after job pop")
    `BVW_ASSERT(a_idle_no_push, state_reg == WALK_RUN || !out_push, "push while idle")

endmodule

@@ rtl/bresenham_3d_ray_voxel_walker.sv @@
// 3D Bresenham ray walker over a voxel grid.
// Input queue: drive a ray (start_*, end_*) with push; a transaction completes
// on a rising edge with push high and full low. Rays whose end cell lies
// outside grid_size_x / grid_size_y are dropped and yield no voxels.
// Result queue: while empty is low the oldest voxel is on voxel_x/y/z and
// ray_last; pop high with empty low takes it. ray_last marks the final voxel
// of a ray; a ray yielding no voxels yields nothing at all.
// Config: cfg_we high writes cfg_data to register cfg_index (0: grid_size_x,
// 1: grid_size_y) on the same edge; write only while the block is idle.
// Timing: accepted rays go through a short job queue to the walker. The
// walker loads a ray while idle, then takes one Bresenham step per cycle
// while the result queue is not full. It closes the ray when the major axis
// reaches its end, the step count reaches its limit, or a step would land
// on the end column (that step is not taken). Each voxel is held in the
// walker until the next step or the close, then enters the result queue.
// When pop stays low the result queue fills, the walker pauses, the job queue
// fills and full rises; nothing is lost. Reset empties both queues, idles the
// walker and sets both grid sizes to 64.
module bresenham_3d_ray_voxel_walker
    import bvw_pkg::*;
#(
    parameter int GRID_MAX  = 64,
    parameter int JOB_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  logic [COORD_W-1:0]   start_z,
    input  logic [COORD_W-1:0]   end_x,
    input  logic [COORD_W-1:0]   end_y,
    input  logic [COORD_W-1:0]   end_z,
    output logic                 empty,
    input  logic                 pop,
    output logic [COORD_W-1:0]   voxel_x,
    output logic [COORD_W-1:0]   voxel_y,
    output logic [COORD_W-1:0]   voxel_z,
    output logic                 ray_last
);

    localparam int JOB_W = $bits(job_t);
    localparam int VOX_W = $bits(voxel_t);

    job_t             job_in, job_out;
    logic [JOB_W-1:0] job_rdata;
    logic             job_push, job_pop, job_full, job_empty;
    voxel_t           vox_in, vox_out;
    logic [VOX_W-1:0] vox_rdata;
    logic             vox_push, vox_full;

    bvw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .job_full  (job_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    bvw_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    assign job_out = job_t'(job_rdata);

    bvw_walker #(
        .GRID_MAX (GRID_MAX)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_full  (vox_full),
        .out_push  (vox_push),
        .out_voxel (vox_in)
    );

    bvw_fifo #(
        .WIDTH (VOX_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (vox_push),
        .wdata (vox_in),
        .full  (vox_full),
        .pop   (pop),
        .rdata (vox_rdata),
        .empty (empty)
    );

    assign vox_out  = voxel_t'(vox_rdata);
    assign voxel_x  = vox_out.x;
    assign voxel_y  = vox_out.y;
    assign voxel_z  = vox_out.z;
    assign ray_last = vox_out.last;

endmodule

@@ tb/bvw_ray_checker.sv @@
module bvw_ray_checker
    import bvw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  logic [COORD_W-1:0]   start_z,
    input  logic [COORD_W-1:0]   end_x,
    input  logic [COORD_W-1:0]   end_y,
    input  logic [COORD_W-1:0]   end_z,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [COORD_W-1:0]   voxel_x,
    input  logic [COORD_W-1:0]   voxel_y,
    input  logic [COORD_W-1:0]   voxel_z,
    input  logic                 ray_last,
    output int                   mismatch_total,
    output int                   voxels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WALK_STEP_LIMIT = 63;
    localparam int PRINT_LIMIT     = 40;

    logic [CFG_W-1:0] grid_x;
    logic [CFG_W-1:0] grid_y;
    voxel_t           expected_voxels[$];
    int               mismatch_count = 0;

    assign mismatch_total = mismatch_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Walks one ray and queues each voxel it steps to before the end column; a ray ending outside the grid queues none.
    function automatic void walk_ray(input coord_t sx, input coord_t sy, input coord_t sz,
                                     input coord_t ex, input coord_t ey, input coord_t ez);
        int     cur[3];
        int     dst[3];
        int     span[3];
        int     dir[3];
        int     err1;
        int     err2;
        int     steps;
        axis_t  major;
        axis_t  minor1;
        axis_t  minor2;
        voxel_t path[$];
        voxel_t v;

        if (ex >= grid_x || ey >= grid_y)
        begin
            return;
        end
        cur[0] = int'(sx);
        cur[1] = int'(sy);
        cur[2] = int'(sz);
        dst[0] = int'(ex);
        dst[1] = int'(ey);
        dst[2] = int'(ez);
        for (int i = 0; i < 3; i++)
        begin
            span[i] = (dst[i] > cur[i]) ? dst[i] - cur[i] : cur[i] - dst[i];
            dir[i]  = (dst[i] > cur[i]) ? 1 : -1;
        end

        // ties go to x, then y
        if (span[0] >= span[1] && span[0] >= span[2])
        begin
            major  = AXIS_X;
            minor1 = AXIS_Y;
            minor2 = AXIS_Z;
        end
        else if (span[1] >= span[0] && span[1] >= span[2])
        begin
            major  = AXIS_Y;
            minor1 = AXIS_X;
            minor2 = AXIS_Z;
        end
        else
        begin
            major  = AXIS_Z;
            minor1 = AXIS_Y;
            minor2 = AXIS_X;
        end

        err1  = 2 * span[minor1] - span[major];
        err2  = 2 * span[minor2] - span[major];
        steps = 0;
        while (cur[major] != dst[major] && steps < WALK_STEP_LIMIT)
        begin
            steps++;
            cur[major] += dir[major];
            if (err1 >= 0)
            begin
                cur[minor1] += dir[minor1];
                err1 -= 2 * span[major];
            end
            if (err2 >= 0)
            begin
                cur[minor2] += dir[minor2];
                err2 -= 2 * span[major];
            end
            err1 += 2 * span[minor1];
            err2 += 2 * span[minor2];
            // reaching the end column stops the walk before it is emitted
            if (cur[0] == dst[0] && cur[1] == dst[1])
            begin
                break;
            end
            v.x    = coord_t'(cur[0]);
            v.y    = coord_t'(cur[1]);
            v.z    = coord_t'(cur[2]);
            v.last = 1'b0;
            path   = {path, v};
        end

        if (path.size() > 0)
        begin
            path[path.size()-1].last = 1'b1;
        end
        foreach (path[i])
        begin
            expected_voxels = {expected_voxels, path[i]};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        voxel_t got;
        voxel_t want;
        string  bad;

        if (!rst_n)
        begin
            grid_x = GRID_RESET;
            grid_y = GRID_RESET;
            expected_voxels.delete();
            voxels_pending <= 0;
        end
        else
        begin
            // results first: a ray accepted at this edge cannot be on the output yet
            if (pop === 1'b1 && empty === 1'b0)
            begin
                got.x    = voxel_x;
                got.y    = voxel_y;
                got.z    = voxel_z;
                got.last = ray_last;
                if (expected_voxels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected voxel %0d,%0d,%0d last %0b",
                                              got.x, got.y, got.z, got.last));
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    bad  = "";
                    if (got.x !== want.x)
                    begin
                        bad = {bad, " voxel_x"};
                    end
                    if (got.y !== want.y)
                    begin
                        bad = {bad, " voxel_y"};
                    end
                    if (got.z !== want.z)
                    begin
                        bad = {bad, " voxel_z"};
                    end
                    if (got.last !== want.last)
                    begin
                        bad = {bad, " ray_last"};
                    end
                    if (bad.len() != 0)
                    begin
                        report_mismatch($sformatf(
                            "wrong%s: got %0d,%0d,%0d last %0b, want %0d,%0d,%0d last %0b",
                            bad, got.x, got.y, got.z, got.last,
                            want.x, want.y, want.z, want.last));
                    end
                end
            end

            // a ray accepted at this edge still sees the old grid sizes
            if (push === 1'b1 && full === 1'b0)
            begin
                walk_ray(start_x, start_y, start_z, end_x, end_y, end_z);
            end

            if (cfg_we === 1'b1)
            begin
                if (cfg_index == REG_GRID_X)
                begin
                    grid_x = cfg_data;
                end
                else if (cfg_index == REG_GRID_Y)
                begin
                    grid_y = cfg_data;
                end
            end

            voxels_pending <= expected_voxels.size();
        end
    end

    final
    begin
    end

endmodule

@@ tb/bresenham_3d_ray_voxel_walker_tb.sv @@
module bresenham_3d_ray_voxel_walker_tb
    import bvw_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   start_z;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic [COORD_W-1:0]   end_z;
    logic                 empty;
    logic                 pop;
    logic [COORD_W-1:0]   voxel_x;
    logic [COORD_W-1:0]   voxel_y;
    logic [COORD_W-1:0]   voxel_z;
    logic                 ray_last;
    int                   mismatch_total;
    int                   voxels_pending;

    int unsigned          cycle_count = 0;
    int                   grid_x = 64;
    int                   grid_y = 64;
    bit                   calm = 1'b0;
    bit                   hold_rx = 1'b0;

    int                   phase_gx[PHASES]    = '{64, 127, 40, 0, 1, 64};
    int                   phase_gy[PHASES]    = '{64, 1, 23, 64, 127, 64};
    int                   phase_rays[PHASES]  = '{50, 25, 55, 8, 20, 50};
    int                   phase_hold[PHASES]  = '{-1, -1, 10, -1, -1, -1};

    bresenham_3d_ray_voxel_walker i_dut (.*);

    bvw_ray_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // result side: random pop bursts, one long hold-off on request
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 9)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_ray(input coord_t sx, input coord_t sy, input coord_t sz,
                            input coord_t ex, input coord_t ey, input coord_t ez);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start_x <= sx;
        start_y <= sy;
        start_z <= sz;
        end_x   <= ex;
        end_y   <= ey;
        end_z   <= ez;
        push    <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full !== 1'b0);
    endtask

    // returns at a rising edge once every voxel is back and the walker has settled
    task automatic wait_idle();
        @(negedge clk);
        while (voxels_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(input int gx, input int gy);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_X;
        cfg_data  <= CFG_W'(gx);
        @(posedge clk);
        cfg_index <= REG_GRID_Y;
        cfg_data  <= CFG_W'(gy);
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_x = gx;
        grid_y = gy;
    endtask

    task automatic random_rays(input int count, input int hold_at);
        coord_t sx, sy, sz, ex, ey, ez;
        int     shape;
        int     top_x;
        int     top_y;

        top_x = (grid_x > 64 ? 64 : grid_x) - 1;
        top_y = (grid_y > 64 ? 64 : grid_y) - 1;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
            begin
                hold_rx = 1'b1;
            end
            shape = $urandom_range(0, 9);
            // mostly rays that land inside the grid; shape 0, or a zero grid size, may land anywhere
            ex = (top_x >= 0 && shape != 0) ? coord_t'($urandom_range(0, top_x))
                                            : coord_t'($urandom_range(0, 63));
            ey = (top_y >= 0 && shape != 0) ? coord_t'($urandom_range(0, top_y))
                                            : coord_t'($urandom_range(0, 63));
            ez = coord_t'($urandom_range(0, 63));
            sz = coord_t'($urandom_range(0, 63));
            if (shape == 1)
            begin
                sx = ex;
                sy = ey;
            end
            else if (shape <= 3)
            begin
                sx = coord_t'(int'(ex) + $urandom_range(0, 6) - 3);
                sy = coord_t'(int'(ey) + $urandom_range(0, 6) - 3);
                sz = coord_t'(int'(ez) + $urandom_range(0, 6) - 3);
            end
            else
            begin
                sx = coord_t'($urandom_range(0, 63));
                sy = coord_t'($urandom_range(0, 63));
            end
            send_ray(sx, sy, sz, ex, ey, ez);
        end
        push <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_GRID_X;
        cfg_data  = '0;
        push      = 1'b0;
        start_x   = '0;
        start_y   = '0;
        start_z   = '0;
        end_x     = '0;
        end_y     = '0;
        end_z     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rays on the reset grid
        send_ray(0, 0, 0, 63, 63, 63);
        send_ray(63, 63, 63, 0, 0, 0);
        send_ray(0, 63, 0, 63, 0, 63);
        send_ray(5, 5, 0, 5, 5, 63);        // start column is the end column
        send_ray(7, 7, 7, 7, 7, 7);         // zero-length ray
        send_ray(0, 0, 0, 1, 0, 0);         // one step lands on the end column
        send_ray(0, 0, 0, 2, 1, 0);
        send_ray(10, 20, 30, 50, 20, 30);   // y and z never step
        send_ray(0, 0, 0, 20, 20, 5);       // x/y tie
        send_ray(0, 0, 0, 5, 20, 20);       // y/z tie
        send_ray(0, 0, 0, 20, 5, 20);       // x/z tie
        send_ray(30, 30, 0, 33, 32, 60);    // z major, column reached early
        send_ray(40, 2, 9, 3, 60, 17);
        send_ray(1, 62, 63, 62, 1, 0);
        send_ray(32, 16, 48, 31, 47, 0);
        send_ray(0, 0, 63, 0, 1, 0);
        send_ray(63, 0, 0, 0, 63, 63);
        send_ray(21, 42, 42, 42, 21, 21);
        push <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_grid(phase_gx[p], phase_gy[p]);
            if (p == PHASES - 1)
            begin
                calm = 1'b1;
            end
            random_rays(phase_rays[p], phase_hold[p]);
        end

        wait_idle();
        if (mismatch_total == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bvw_pkg.sv
rtl/bvw_fifo.sv
rtl/bvw_front.sv
rtl/bvw_walker.sv
rtl/bresenham_3d_ray_voxel_walker.sv
tb/bvw_ray_checker.sv
tb/bresenham_3d_ray_voxel_walker_tb.sv
